>>> hw/rtl/inverted_index_set_pruner_macros.svh
// assertion macros shared by the pruner rtl
// expects clk and rst_n in the scope of use
`ifndef INVERTED_INDEX_SET_PRUNER_MACROS_SVH
`define INVERTED_INDEX_SET_PRUNER_MACROS_SVH

// property that must hold at every edge out of reset
`define IISP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold on the edge after a trigger
`define IISP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/iisp_pkg.sv
// shared types and constants of the inverted index set pruner
// no dependencies
`default_nettype none

package iisp_pkg;

    localparam int TERM_W   = 8;
    localparam int DOC_W    = 10;
    localparam int STATUS_W = 3;
    localparam int KCNT_W   = 7;
    localparam int RCNT_W   = 11;
    localparam int FRAC_W   = 9;
    localparam int MINK_W   = 7;
    localparam int MINR_W   = 11;
    localparam int CFGD_W   = 11;
    localparam int CFGI_W   = 2;
    localparam int VOTE_W   = 12;
    localparam logic [VOTE_W-1:0] VOTE_MAX = 12'hFFF;
    localparam int QD       = 2;

    localparam logic [STATUS_W-1:0] ST_KEPT_TERM = 3'd0;
    localparam logic [STATUS_W-1:0] ST_KEPT_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POST_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

    localparam logic [CFGI_W-1:0] CFG_OVERLAP = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_COOCCUR = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_MIN_KEPT = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_MIN_RETR = 2'd3;

    typedef enum logic [1:0] {
        OP_APPEND     = 2'd0,
        OP_APPEND_BAD = 2'd1,
        OP_TERM       = 2'd2,
        OP_TERM_LAST  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [TERM_W-1:0] term;
        logic [DOC_W-1:0]  doc;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } q_t;

    typedef struct packed {
        logic pop;
        logic accept_en;
    } bctl_t;

    typedef struct packed {
        logic [FRAC_W-1:0] overlap;
        logic [FRAC_W-1:0] cooccur;
        logic [MINK_W-1:0] min_kept;
        logic [MINR_W-1:0] min_retr;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/iisp_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module iisp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] wa,
    input  wire logic [W-1:0]                  wd,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] ra,
    output logic      [W-1:0]                  rd
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

`default_nettype wire

>>> hw/rtl/iisp_front.sv
// front end: takes input transactions, classifies them, queues them
// depends on iisp_pkg and the macro header
`default_nettype none
`include "inverted_index_set_pruner_macros.svh"

module iisp_front
    import iisp_pkg::*;
#(
    parameter int VOCAB = 256,
    parameter int DOCS  = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic              cmd,
    input  wire logic [TERM_W-1:0] term,
    input  wire logic [DOC_W-1:0]  doc,
    input  wire logic              last,
    output q_t                     q,
    input  wire bctl_t             bctl
);

    localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    qent_t           buf_reg [QD];
    logic [QPW-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [QCW-1:0]  cnt_reg, cnt_next;
    qent_t           ent;
    logic            push, pop;

    // classify on the way in
    always_comb
    begin
        ent.term = term;
        ent.doc  = doc;
        if (!cmd)
        begin
            if ((32'(term) < VOCAB) && (32'(doc) < DOCS))
            begin
                ent.op = OP_APPEND;
            end
            else
            begin
                ent.op = OP_APPEND_BAD;
            end
        end
        else if (last)
        begin
            ent.op = OP_TERM_LAST;
        end
        else
        begin
            ent.op = OP_TERM;
        end
    end

    assign item_stall = (32'(cnt_reg) == QD) || !bctl.accept_en;
    assign push       = item_valid && !item_stall;
    assign pop        = bctl.pop && (cnt_reg != '0);
    assign q.valid    = (cnt_reg != '0);
    assign q.ent      = buf_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (32'(wr_reg) == QD - 1) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (32'(rd_reg) == QD - 1) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= ent;
        end
    end

    `IISP_ASSERT_ALWAYS(a_q_count, 32'(cnt_reg) <= QD, "queue count overrun")

endmodule

`default_nettype wire

>>> hw/rtl/iisp_back.sv
// back end: posting store, set evaluation sequencer and result register
// depends on iisp_pkg, iisp_ram and the macro header
`default_nettype none
`include "inverted_index_set_pruner_macros.svh"

module iisp_back
    import iisp_pkg::*;
#(
    parameter int VOCAB       = 256,
    parameter int MAX_POSTING = 32,
    parameter int DOCS        = 1024,
    parameter int MAX_SET     = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire q_t                  q,
    output bctl_t                    bctl,
    input  wire cfg_t                cfg,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [TERM_W-1:0]        kept_term,
    output logic [KCNT_W-1:0]        kept_count,
    output logic [RCNT_W-1:0]        retrieved_count,
    output logic                     last_res
);

    localparam int VA    = (VOCAB > 1) ? $clog2(VOCAB) : 1;
    localparam int PD    = VOCAB * MAX_POSTING;
    localparam int PA    = (PD > 1) ? $clog2(PD) : 1;
    localparam int DA    = (DOCS > 1) ? $clog2(DOCS) : 1;
    localparam int SA    = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
    localparam int LEN_W = $clog2(MAX_POSTING + 1);
    localparam int SSW   = $clog2(MAX_SET + 1);
    localparam int RTW   = $clog2(DOCS + 1);
    localparam int CLR_N = (VOCAB > DOCS) ? VOCAB : DOCS;
    localparam int CLRW  = $clog2(CLR_N);
    localparam int OVW   = SSW + FRAC_W;
    localparam int COW   = RTW + FRAC_W;

    typedef enum logic [20:0] {
        S_CLEAR     = 21'h000001,
        S_IDLE      = 21'h000002,
        S_APP_LEN   = 21'h000004,
        S_FIN_START = 21'h000008,
        S_TERM      = 21'h000010,
        S_TERM_W    = 21'h000020,
        S_LEN_W     = 21'h000040,
        S_POST      = 21'h000080,
        S_POST_W    = 21'h000100,
        S_VOTE_W    = 21'h000200,
        S_TEND      = 21'h000400,
        S_RET       = 21'h000800,
        S_RET_T     = 21'h001000,
        S_RET_V     = 21'h002000,
        S_THR       = 21'h004000,
        S_ZERO      = 21'h008000,
        S_ZERO_W    = 21'h010000,
        S_DECIDE    = 21'h020000,
        S_EMIT      = 21'h040000,
        S_EMIT_W    = 21'h080000,
        S_REPLY     = 21'h100000
    } state_t;

    state_t               state_reg, state_next;
    logic [SSW-1:0]       set_size_reg, set_size_next;
    logic                 ovf_reg, ovf_next;
    logic [SSW-1:0]       fin_size_reg, fin_size_next;
    logic [SSW-1:0]       i_reg, i_next;
    logic [RTW-1:0]       k_reg, k_next;
    logic [LEN_W-1:0]     j_reg, j_next;
    logic [TERM_W-1:0]    t_reg, t_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [DOC_W-1:0]     d_reg, d_next;
    logic [RTW-1:0]       touched_reg, touched_next;
    logic [RTW-1:0]       retr_reg, retr_next;
    logic [SSW-1:0]       kept_reg, kept_next;
    logic [SSW-1:0]       seen_reg, seen_next;
    logic [LEN_W-1:0]     hits_reg, hits_next;
    logic [OVW-1:0]       thr_ov_reg, thr_ov_next;
    logic [COW-1:0]       thr_co_reg, thr_co_next;
    logic                 pass3_reg, pass3_next;
    qent_t                ent_reg, ent_next;
    logic [CLRW-1:0]      clr_reg, clr_next;
    logic [STATUS_W-1:0]  rep_status_reg, rep_status_next;
    logic [SSW-1:0]       rep_kept_reg, rep_kept_next;
    logic [RTW-1:0]       rep_retr_reg, rep_retr_next;
    logic                 ov_reg, ov_next;
    logic [STATUS_W-1:0]  o_status_reg, o_status_next;
    logic [TERM_W-1:0]    o_term_reg, o_term_next;
    logic [KCNT_W-1:0]    o_kept_reg, o_kept_next;
    logic [RCNT_W-1:0]    o_retr_reg, o_retr_next;
    logic                 o_last_reg, o_last_next;

    logic                 len_we;
    logic [VA-1:0]        len_wa, len_ra;
    logic [LEN_W-1:0]     len_wd, len_rd;
    logic                 post_we;
    logic [PA-1:0]        post_wa, post_ra;
    logic [DOC_W-1:0]     post_wd, post_rd;
    logic                 set_we;
    logic [SA-1:0]        set_wa, set_ra;
    logic [TERM_W-1:0]    set_wd, set_rd;
    logic                 keep_we, keep_wd, keep_rd;
    logic [SA-1:0]        keep_wa;
    logic                 vote_we;
    logic [DA-1:0]        vote_wa, vote_ra;
    logic [VOTE_W-1:0]    vote_wd, vote_rd;
    logic                 touch_we;
    logic [DA-1:0]        touch_wa, touch_ra;
    logic [DOC_W-1:0]     touch_wd, touch_rd;

    logic                 out_free;
    logic                 set_full;
    logic                 keep_now;

    iisp_ram #(.W(LEN_W), .D(VOCAB)) u_len_ram (
        .clk(clk), .we(len_we), .wa(len_wa), .wd(len_wd), .ra(len_ra), .rd(len_rd)
    );
    iisp_ram #(.W(DOC_W), .D(PD)) u_post_ram (
        .clk(clk), .we(post_we), .wa(post_wa), .wd(post_wd), .ra(post_ra), .rd(post_rd)
    );
    iisp_ram #(.W(TERM_W), .D(MAX_SET)) u_set_ram (
        .clk(clk), .we(set_we), .wa(set_wa), .wd(set_wd), .ra(set_ra), .rd(set_rd)
    );
    iisp_ram #(.W(1), .D(MAX_SET)) u_keep_ram (
        .clk(clk), .we(keep_we), .wa(keep_wa), .wd(keep_wd), .ra(set_ra), .rd(keep_rd)
    );
    iisp_ram #(.W(VOTE_W), .D(DOCS)) u_vote_ram (
        .clk(clk), .we(vote_we), .wa(vote_wa), .wd(vote_wd), .ra(vote_ra), .rd(vote_rd)
    );
    iisp_ram #(.W(DOC_W), .D(DOCS)) u_touch_ram (
        .clk(clk), .we(touch_we), .wa(touch_wa), .wd(touch_wd), .ra(touch_ra), .rd(touch_rd)
    );

    assign out_free = !ov_reg || !res_stall;
    assign set_full = 32'(set_size_reg) >= MAX_SET;
    assign keep_now = 32'({hits_reg, 8'b0}) >= 32'(thr_co_reg);

    always_comb
    begin
        state_next      = state_reg;
        set_size_next   = set_size_reg;
        ovf_next        = ovf_reg;
        fin_size_next   = fin_size_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        t_next          = t_reg;
        len_next        = len_reg;
        d_next          = d_reg;
        touched_next    = touched_reg;
        retr_next       = retr_reg;
        kept_next       = kept_reg;
        seen_next       = seen_reg;
        hits_next       = hits_reg;
        thr_ov_next     = thr_ov_reg;
        thr_co_next     = thr_co_reg;
        pass3_next      = pass3_reg;
        ent_next        = ent_reg;
        clr_next        = clr_reg;
        rep_status_next = rep_status_reg;
        rep_kept_next   = rep_kept_reg;
        rep_retr_next   = rep_retr_reg;
        ov_next         = ov_reg;
        o_status_next   = o_status_reg;
        o_term_next     = o_term_reg;
        o_kept_next     = o_kept_reg;
        o_retr_next     = o_retr_reg;
        o_last_next     = o_last_reg;

        len_we   = 1'b0;
        len_wa   = VA'(ent_reg.term);
        len_wd   = '0;
        len_ra   = '0;
        post_we  = 1'b0;
        post_wa  = '0;
        post_wd  = ent_reg.doc;
        post_ra  = PA'(t_reg) * PA'(MAX_POSTING) + PA'(j_reg);
        set_we   = 1'b0;
        set_wa   = set_size_reg[SA-1:0];
        set_wd   = q.ent.term;
        set_ra   = i_reg[SA-1:0];
        keep_we  = 1'b0;
        keep_wa  = i_reg[SA-1:0];
        keep_wd  = keep_now;
        vote_we  = 1'b0;
        vote_wa  = DA'(d_reg);
        vote_wd  = '0;
        vote_ra  = DA'(post_rd);
        touch_we = 1'b0;
        touch_wa = touched_reg[DA-1:0];
        touch_wd = d_reg;
        touch_ra = k_reg[DA-1:0];

        bctl.pop       = 1'b0;
        bctl.accept_en = (state_reg != S_CLEAR);

        if (ov_reg && !res_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // sweep lengths and vote counters to zero
                if (32'(clr_reg) < VOCAB)
                begin
                    len_we = 1'b1;
                    len_wa = clr_reg[VA-1:0];
                end
                if (32'(clr_reg) < DOCS)
                begin
                    vote_we = 1'b1;
                    vote_wa = clr_reg[DA-1:0];
                end
                if (32'(clr_reg) == CLR_N - 1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (q.valid)
                begin
                    bctl.pop = 1'b1;
                    ent_next = q.ent;
                    case (q.ent.op)
                        OP_APPEND:
                        begin
                            len_ra     = VA'(q.ent.term);
                            state_next = S_APP_LEN;
                        end
                        OP_APPEND_BAD:
                        begin
                            rep_status_next = ST_POST_FULL;
                            rep_kept_next   = '0;
                            rep_retr_next   = '0;
                            state_next      = S_REPLY;
                        end
                        OP_TERM, OP_TERM_LAST:
                        begin
                            if (!set_full)
                            begin
                                set_we        = 1'b1;
                                set_size_next = set_size_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            if (q.ent.op == OP_TERM_LAST)
                            begin
                                if (ovf_reg || set_full)
                                begin
                                    set_size_next   = '0;
                                    ovf_next        = 1'b0;
                                    rep_status_next = ST_TOO_LONG;
                                    rep_kept_next   = '0;
                                    rep_retr_next   = '0;
                                    state_next      = S_REPLY;
                                end
                                else
                                begin
                                    state_next = S_FIN_START;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_APP_LEN:
            begin
                if (32'(len_rd) >= MAX_POSTING)
                begin
                    rep_status_next = ST_POST_FULL;
                    rep_kept_next   = '0;
                    rep_retr_next   = '0;
                    state_next      = S_REPLY;
                end
                else
                begin
                    post_we    = 1'b1;
                    post_wa    = PA'(VA'(ent_reg.term)) * PA'(MAX_POSTING) + PA'(len_rd);
                    len_we     = 1'b1;
                    len_wd     = len_rd + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN_START:
            begin
                fin_size_next = set_size_reg;
                set_size_next = '0;
                ovf_next      = 1'b0;
                thr_ov_next   = OVW'(set_size_reg) * OVW'(cfg.overlap);
                i_next        = '0;
                pass3_next    = 1'b0;
                touched_next  = '0;
                retr_next     = '0;
                kept_next     = '0;
                state_next    = S_TERM;
            end
            S_TERM:
            begin
                if (i_reg == fin_size_reg)
                begin
                    k_next = '0;
                    if (pass3_reg)
                    begin
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        state_next = S_RET;
                    end
                end
                else
                begin
                    state_next = S_TERM_W;
                end
            end
            S_TERM_W:
            begin
                t_next    = set_rd;
                hits_next = '0;
                if (32'(set_rd) < VOCAB)
                begin
                    len_ra     = VA'(set_rd);
                    state_next = S_LEN_W;
                end
                else
                begin
                    state_next = S_TEND;
                end
            end
            S_LEN_W:
            begin
                len_next = len_rd;
                j_next   = '0;
                if (len_rd == '0)
                begin
                    state_next = S_TEND;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                state_next = S_POST_W;
            end
            S_POST_W:
            begin
                d_next     = post_rd;
                state_next = S_VOTE_W;
            end
            S_VOTE_W:
            begin
                if (pass3_reg)
                begin
                    if (vote_rd != '0)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                end
                else
                begin
                    // first vote for a document records it for later passes
                    if ((vote_rd == '0) && (32'(touched_reg) < DOCS))
                    begin
                        touch_we     = 1'b1;
                        touched_next = touched_reg + 1'b1;
                    end
                    vote_we = 1'b1;
                    vote_wd = (vote_rd == VOTE_MAX) ? vote_rd : vote_rd + 1'b1;
                end
                j_next = j_reg + 1'b1;
                if (j_reg + 1'b1 == len_reg)
                begin
                    state_next = S_TEND;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_TEND:
            begin
                if (pass3_reg)
                begin
                    keep_we = 1'b1;
                    if (keep_now)
                    begin
                        kept_next = kept_reg + 1'b1;
                    end
                end
                i_next     = i_reg + 1'b1;
                state_next = S_TERM;
            end
            S_RET:
            begin
                if (k_reg == touched_reg)
                begin
                    state_next = S_THR;
                end
                else
                begin
                    state_next = S_RET_T;
                end
            end
            S_RET_T:
            begin
                d_next     = touch_rd;
                vote_ra    = DA'(touch_rd);
                state_next = S_RET_V;
            end
            S_RET_V:
            begin
                if (32'({vote_rd, 8'b0}) < 32'(thr_ov_reg))
                begin
                    vote_we = 1'b1;
                end
                else
                begin
                    retr_next = retr_reg + 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = S_RET;
            end
            S_THR:
            begin
                thr_co_next = COW'(retr_reg) * COW'(cfg.cooccur);
                i_next      = '0;
                pass3_next  = 1'b1;
                state_next  = S_TERM;
            end
            S_ZERO:
            begin
                if (k_reg == touched_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_ZERO_W;
                end
            end
            S_ZERO_W:
            begin
                vote_we    = 1'b1;
                vote_wa    = DA'(touch_rd);
                k_next     = k_reg + 1'b1;
                state_next = S_ZERO;
            end
            S_DECIDE:
            begin
                if ((32'(kept_reg) >= 32'(cfg.min_kept)) &&
                    (32'(retr_reg) >= 32'(cfg.min_retr)))
                begin
                    if (kept_reg == '0)
                    begin
                        rep_status_next = ST_KEPT_EMPTY;
                        rep_kept_next   = '0;
                        rep_retr_next   = retr_reg;
                        state_next      = S_REPLY;
                    end
                    else
                    begin
                        i_next     = '0;
                        seen_next  = '0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    rep_status_next = ST_REJECTED;
                    rep_kept_next   = kept_reg;
                    rep_retr_next   = retr_reg;
                    state_next      = S_REPLY;
                end
            end
            S_EMIT:
            begin
                if (i_reg == fin_size_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT_W;
                end
            end
            S_EMIT_W:
            begin
                if (!keep_rd)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_EMIT;
                end
                else if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = ST_KEPT_TERM;
                    o_term_next   = set_rd;
                    o_kept_next   = KCNT_W'(kept_reg);
                    o_retr_next   = RCNT_W'(retr_reg);
                    o_last_next   = (seen_reg + 1'b1 == kept_reg);
                    seen_next     = seen_reg + 1'b1;
                    i_next        = i_reg + 1'b1;
                    if (seen_reg + 1'b1 == kept_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = rep_status_reg;
                    o_term_next   = '0;
                    o_kept_next   = KCNT_W'(rep_kept_reg);
                    o_retr_next   = RCNT_W'(rep_retr_reg);
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            set_size_reg <= '0;
            ovf_reg      <= 1'b0;
            fin_size_reg <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            touched_reg  <= '0;
            retr_reg     <= '0;
            kept_reg     <= '0;
            seen_reg     <= '0;
            hits_reg     <= '0;
            pass3_reg    <= 1'b0;
            clr_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            set_size_reg <= set_size_next;
            ovf_reg      <= ovf_next;
            fin_size_reg <= fin_size_next;
            i_reg        <= i_next;
            k_reg        <= k_next;
            j_reg        <= j_next;
            touched_reg  <= touched_next;
            retr_reg     <= retr_next;
            kept_reg     <= kept_next;
            seen_reg     <= seen_next;
            hits_reg     <= hits_next;
            pass3_reg    <= pass3_next;
            clr_reg      <= clr_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg          <= t_next;
        len_reg        <= len_next;
        d_reg          <= d_next;
        thr_ov_reg     <= thr_ov_next;
        thr_co_reg     <= thr_co_next;
        ent_reg        <= ent_next;
        rep_status_reg <= rep_status_next;
        rep_kept_reg   <= rep_kept_next;
        rep_retr_reg   <= rep_retr_next;
        o_status_reg   <= o_status_next;
        o_term_reg     <= o_term_next;
        o_kept_reg     <= o_kept_next;
        o_retr_reg     <= o_retr_next;
        o_last_reg     <= o_last_next;
    end

    assign res_valid       = ov_reg;
    assign status          = o_status_reg;
    assign kept_term       = o_term_reg;
    assign kept_count      = o_kept_reg;
    assign retrieved_count = o_retr_reg;
    assign last_res        = o_last_reg;

    `IISP_ASSERT_ALWAYS(a_kept_bound, kept_reg <= fin_size_reg, "kept count beyond set size")
    `IISP_ASSERT_ALWAYS(a_retr_bound, retr_reg <= touched_reg, "retrieved beyond touched")
    `IISP_ASSERT_NEXT(a_clear_quiet, state_reg == S_CLEAR, !ov_reg, "result during clear")

endmodule

`default_nettype wire

>>> hw/rtl/inverted_index_set_pruner.sv
// The back end handles one queued transaction at a time; the front queue takes new
// items while it is busy, until the queue is full. A closing term walks the set's
// posting lists to vote, the touched documents to retrieve, the lists again to
// keep terms and the touched documents to clear votes; result stalls can hold it.
// After reset a clearing pass zeroes the posting lengths and vote counters;
// no transaction is taken until it ends.
// top level: configuration registers, front queue and back sequencer
// depends on iisp_pkg, iisp_front and iisp_back
`default_nettype none

module inverted_index_set_pruner
    import iisp_pkg::*;
#(
    parameter int VOCAB       = 256,
    parameter int MAX_POSTING = 32,
    parameter int DOCS        = 1024,
    parameter int MAX_SET     = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFGI_W-1:0]   cfg_index,
    input  wire logic [CFGD_W-1:0]   cfg_data,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic                cmd,
    input  wire logic [TERM_W-1:0]   term,
    input  wire logic [DOC_W-1:0]    doc,
    input  wire logic                last,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [TERM_W-1:0]        kept_term,
    output logic [KCNT_W-1:0]        kept_count,
    output logic [RCNT_W-1:0]        retrieved_count,
    output logic                     last_res
);

    cfg_t  cfg_reg, cfg_next;
    q_t    q;
    bctl_t bctl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OVERLAP:  cfg_next.overlap  = cfg_data[FRAC_W-1:0];
                CFG_COOCCUR:  cfg_next.cooccur  = cfg_data[FRAC_W-1:0];
                CFG_MIN_KEPT: cfg_next.min_kept = cfg_data[MINK_W-1:0];
                CFG_MIN_RETR: cfg_next.min_retr = cfg_data[MINR_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlap  <= 9'd128;
            cfg_reg.cooccur  <= 9'd128;
            cfg_reg.min_kept <= 7'd1;
            cfg_reg.min_retr <= 11'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    iisp_front #(
        .VOCAB(VOCAB),
        .DOCS(DOCS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .cmd(cmd),
        .term(term),
        .doc(doc),
        .last(last),
        .q(q),
        .bctl(bctl)
    );

    iisp_back #(
        .VOCAB(VOCAB),
        .MAX_POSTING(MAX_POSTING),
        .DOCS(DOCS),
        .MAX_SET(MAX_SET)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q(q),
        .bctl(bctl),
        .cfg(cfg_reg),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .status(status),
        .kept_term(kept_term),
        .kept_count(kept_count),
        .retrieved_count(retrieved_count),
        .last_res(last_res)
    );

endmodule

`default_nettype wire

>>> tb/tb_inverted_index_set_pruner.sv
// testbench for the inverted index set pruner: directed and random transactions
// checked against a behavioural predictor; depends on iisp_pkg and the top level
`default_nettype none

module tb_inverted_index_set_pruner;
    import iisp_pkg::*;

    localparam int VOCAB       = 256;
    localparam int MAX_POSTING = 32;
    localparam int DOCS        = 1024;
    localparam int MAX_SET     = 64;
    localparam int LIMIT       = 3000000;
    localparam bit CMD_APPEND  = 1'b0;
    localparam bit CMD_TERM    = 1'b1;

    typedef struct {
        logic [STATUS_W-1:0] st;
        logic [TERM_W-1:0]   kt;
        logic [KCNT_W-1:0]   kc;
        logic [RCNT_W-1:0]   rc;
        logic                lr;
    } prune_res_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFGI_W-1:0]   cfg_index;
    logic [CFGD_W-1:0]   cfg_data;
    logic                item_valid;
    logic                item_stall;
    logic                cmd;
    logic [TERM_W-1:0]   term;
    logic [DOC_W-1:0]    doc;
    logic                last;
    logic                res_valid;
    logic                res_stall;
    logic [STATUS_W-1:0] status;
    logic [TERM_W-1:0]   kept_term;
    logic [KCNT_W-1:0]   kept_count;
    logic [RCNT_W-1:0]   retrieved_count;
    logic                last_res;

    inverted_index_set_pruner uut (.*);

    // predictor state
    int unsigned ov_frac, co_frac, min_kept, min_retr;
    logic [DOC_W-1:0] post_store [VOCAB][MAX_POSTING];
    int unsigned post_len [VOCAB];
    logic [TERM_W-1:0] set_list [MAX_SET];
    int unsigned set_len;
    bit set_ovf;
    int unsigned doc_votes [DOCS];

    prune_res_t pending_res [$];
    int mismatches;
    int cycles;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_res(logic [STATUS_W-1:0] st, logic [TERM_W-1:0] kt,
                                     int unsigned kc, int unsigned rc, bit lr);
        prune_res_t r;
        r.st = st;
        r.kt = kt;
        r.kc = kc[KCNT_W-1:0];
        r.rc = rc[RCNT_W-1:0];
        r.lr = lr;
        pending_res.push_back(r);
    endfunction

    function automatic void predict_prune(bit c, logic [TERM_W-1:0] t,
                                          logic [DOC_W-1:0] d, bit l);
        int unsigned touched [$];
        int unsigned retr, kept, hits, seen, dd;
        bit keep [MAX_SET];
        if (c == CMD_APPEND)
        begin
            if (post_len[t] >= MAX_POSTING)
                push_res(ST_POST_FULL, '0, 0, 0, 1'b1);
            else
            begin
                post_store[t][post_len[t]] = d;
                post_len[t]++;
            end
            return;
        end
        if (set_len < MAX_SET)
        begin
            set_list[set_len] = t;
            set_len++;
        end
        else
            set_ovf = 1'b1;
        if (!l)
            return;
        if (set_ovf)
        begin
            set_len = 0;
            set_ovf = 1'b0;
            push_res(ST_TOO_LONG, '0, 0, 0, 1'b1);
            return;
        end
        // voting
        for (int i = 0; i < set_len; i++)
            for (int j = 0; j < post_len[set_list[i]]; j++)
            begin
                dd = post_store[set_list[i]][j];
                if (doc_votes[dd] == 0)
                    touched.push_back(dd);
                if (doc_votes[dd] < 4095)
                    doc_votes[dd]++;
            end
        retr = 0;
        foreach (touched[i])
            if (doc_votes[touched[i]] * 256 < set_len * ov_frac)
                doc_votes[touched[i]] = 0;
            else
                retr++;
        kept = 0;
        for (int i = 0; i < set_len; i++)
        begin
            hits = 0;
            for (int j = 0; j < post_len[set_list[i]]; j++)
                if (doc_votes[post_store[set_list[i]][j]] != 0)
                    hits++;
            keep[i] = (hits * 256 >= retr * co_frac);
            if (keep[i])
                kept++;
        end
        if (kept >= min_kept && retr >= min_retr)
        begin
            if (kept == 0)
                push_res(ST_KEPT_EMPTY, '0, 0, retr, 1'b1);
            else
            begin
                seen = 0;
                for (int i = 0; i < set_len; i++)
                    if (keep[i])
                    begin
                        seen++;
                        push_res(ST_KEPT_TERM, set_list[i], kept, retr, seen == kept);
                    end
            end
        end
        else
            push_res(ST_REJECTED, '0, kept, retr, 1'b1);
        foreach (touched[i])
            doc_votes[touched[i]] = 0;
        set_len = 0;
        set_ovf = 1'b0;
    endfunction

    task automatic send_item(bit c, logic [TERM_W-1:0] t, logic [DOC_W-1:0] d, bit l);
        while (!calm && $urandom_range(99) < 25)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        cmd        <= c;
        term       <= t;
        doc        <= d;
        last       <= l;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        predict_prune(c, t, d, l);
    endtask

    task automatic drain;
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        // an append can still be in flight with nothing expected
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFGD_W-1:0];
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            CFG_OVERLAP:  ov_frac  = val & 'h1FF;
            CFG_COOCCUR:  co_frac  = val & 'h1FF;
            CFG_MIN_KEPT: min_kept = val & 'h7F;
            CFG_MIN_RETR: min_retr = val & 'h7FF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int unsigned ov, int unsigned co, int unsigned mk, int unsigned mr);
        write_reg(CFG_OVERLAP, ov);
        write_reg(CFG_COOCCUR, co);
        write_reg(CFG_MIN_KEPT, mk);
        write_reg(CFG_MIN_RETR, mr);
    endtask

    // field extremes, a plain emitted set and repeated terms
    task automatic test_basic_set;
        send_item(CMD_APPEND, 8'd0, 10'd0, 1'b0);
        send_item(CMD_APPEND, 8'd0, 10'd1023, 1'b1);
        send_item(CMD_APPEND, 8'd255, 10'd1023, 1'b0);
        send_item(CMD_APPEND, 8'd1, 10'd5, 1'b0);
        send_item(CMD_TERM, 8'd0, 10'd1023, 1'b0);
        send_item(CMD_TERM, 8'd255, 10'd0, 1'b0);
        send_item(CMD_TERM, 8'd0, 10'd0, 1'b0);
        send_item(CMD_TERM, 8'd1, 10'd0, 1'b1);
        drain();
    endtask

    // empty lists only: nothing retrieved, so rejected under default minimums
    task automatic test_rejected;
        send_item(CMD_TERM, 8'd200, 10'd0, 1'b0);
        send_item(CMD_TERM, 8'd201, 10'd0, 1'b1);
        drain();
    endtask

    // every term below the co-occurrence bar but minimums at zero
    task automatic test_kept_empty;
        set_all(0, 256, 0, 0);
        send_item(CMD_APPEND, 8'd10, 10'd1, 1'b0);
        send_item(CMD_APPEND, 8'd10, 10'd2, 1'b0);
        send_item(CMD_APPEND, 8'd11, 10'd3, 1'b0);
        send_item(CMD_TERM, 8'd10, 10'd0, 1'b0);
        send_item(CMD_TERM, 8'd11, 10'd0, 1'b1);
        drain();
    endtask

    task automatic test_full_list;
        for (int i = 0; i <= MAX_POSTING; i++)
            send_item(CMD_APPEND, 8'd20, 10'(i * 31), 1'b0);
        drain();
    endtask

    task automatic test_too_long;
        for (int i = 0; i <= MAX_SET; i++)
            send_item(CMD_TERM, 8'(i), 10'd0, i == MAX_SET);
        drain();
    endtask

    task automatic test_random_phase(int unsigned ov, int unsigned co, int unsigned mk,
                                     int unsigned mr, int n_items);
        int sent;
        int len;
        sent = 0;
        set_all(ov, co, mk, mr);
        while (sent < n_items)
        begin
            calm = ($urandom_range(99) < 15);
            if ($urandom_range(99) < 55)
            begin
                send_item(CMD_APPEND,
                          ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom),
                          ($urandom_range(99) < 80) ? 10'($urandom_range(40)) : 10'($urandom),
                          1'($urandom));
                sent++;
            end
            else
            begin
                len = ($urandom_range(99) < 3) ? $urandom_range(MAX_SET + 1, MAX_SET + 4)
                                               : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_item(CMD_TERM,
                              ($urandom_range(99) < 85) ? 8'($urandom_range(15))
                                                        : 8'($urandom),
                              10'($urandom), i == len - 1);
                sent += len;
            end
        end
        calm = 1'b0;
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        prune_res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: status %0d term %0d", status,
                             kept_term);
            end
            else
            begin
                e = pending_res.pop_front();
                if (status !== e.st || kept_term !== e.kt || kept_count !== e.kc ||
                    retrieved_count !== e.rc || last_res !== e.lr)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d term %0d kept %0d retr %0d last %0d, got st %0d term %0d kept %0d retr %0d last %0d",
                                 e.st, e.kt, e.kc, e.rc, e.lr, status, kept_term,
                                 kept_count, retrieved_count, last_res);
                end
            end
        end
    end

    always @(negedge clk)
        res_stall <= !calm && ($urandom_range(99) < 25);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[inverted_index_set_pruner] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        cmd        = 1'b0;
        term       = '0;
        doc        = '0;
        last       = 1'b0;
        res_stall  = 1'b0;
        calm       = 1'b0;
        mismatches = 0;
        cycles     = 0;
        ov_frac    = 128;
        co_frac    = 128;
        min_kept   = 1;
        min_retr   = 1;
        set_len    = 0;
        set_ovf    = 1'b0;
        foreach (post_len[i])
            post_len[i] = 0;
        foreach (doc_votes[i])
            doc_votes[i] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_set();
        test_rejected();
        test_full_list();
        test_too_long();
        test_kept_empty();
        test_random_phase(128, 128, 1, 1, 60);
        test_random_phase(0, 0, 0, 0, 60);
        test_random_phase(256, 256, 64, 1024, 45);
        test_random_phase(256, 0, 1, 1, 45);
        test_random_phase($urandom_range(256), $urandom_range(256), $urandom_range(3),
                          $urandom_range(4), 60);
        test_random_phase(64, 192, 2, 3, 45);

        if (mismatches == 0 && pending_res.size() == 0)
            $display("[inverted_index_set_pruner] OK");
        else
            $display("[inverted_index_set_pruner] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/iisp_pkg.sv
hw/rtl/iisp_ram.sv
hw/rtl/iisp_front.sv
hw/rtl/iisp_back.sv
hw/rtl/inverted_index_set_pruner.sv
tb/tb_inverted_index_set_pruner.sv
